// ===== rtl/pcs_pkg.sv =====
// Shared types and constants for the primitive count statistics unit.
package pcs_pkg;

    localparam int unsigned TOPO_BITS = 6;
    localparam int unsigned VERT_BITS = 32;
    localparam int unsigned INST_BITS = 32;
    localparam int unsigned DIVR_BITS = 6;
    localparam int unsigned OUT_BITS  = 64;
    localparam int unsigned DIV_STEPS = VERT_BITS;

    localparam logic [TOPO_BITS-1:0] TOPO_POINTS         = 6'd0;
    localparam logic [TOPO_BITS-1:0] TOPO_LINES          = 6'd1;
    localparam logic [TOPO_BITS-1:0] TOPO_LINE_STRIP     = 6'd2;
    localparam logic [TOPO_BITS-1:0] TOPO_LINE_LOOP      = 6'd3;
    localparam logic [TOPO_BITS-1:0] TOPO_LINES_ADJ      = 6'd4;
    localparam logic [TOPO_BITS-1:0] TOPO_LINE_STRIP_ADJ = 6'd5;
    localparam logic [TOPO_BITS-1:0] TOPO_TRIS           = 6'd6;
    localparam logic [TOPO_BITS-1:0] TOPO_TRI_STRIP      = 6'd7;
    localparam logic [TOPO_BITS-1:0] TOPO_TRI_FAN        = 6'd8;
    localparam logic [TOPO_BITS-1:0] TOPO_TRIS_ADJ       = 6'd9;
    localparam logic [TOPO_BITS-1:0] TOPO_TRI_STRIP_ADJ  = 6'd10;
    localparam logic [TOPO_BITS-1:0] TOPO_PATCH_FIRST    = 6'd11;
    localparam logic [TOPO_BITS-1:0] TOPO_PATCH_LAST     = 6'd42;
    localparam logic [TOPO_BITS-1:0] TOPO_PATCH_BASE     = 6'd10;

    localparam logic [DIVR_BITS-1:0] DIV_ONE  = 6'd1;

    // n/3 for 32-bit n: (n * ceil(2^33/3)) >> 33
    localparam logic [VERT_BITS-1:0] DIV3_RECIP = 32'hAAAA_AAAB;
    localparam int unsigned          DIV3_SHIFT = 33;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_POINT,
        KIND_LINE,
        KIND_TRI,
        KIND_PATCH
    } t_kind;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic                  clear;
        t_kind                 kind;
        logic                  use_div;  // value is n, divide by divisor
        logic [DIVR_BITS-1:0]  divisor;
        logic [VERT_BITS-1:0]  value;    // n, or primitives per instance
        logic [INST_BITS-1:0]  inst;
    } t_cmd;

endpackage

// ===== rtl/pcs_front.sv =====
// Front end: accepts items and classifies them by topology.
module pcs_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_func,
    input  logic [pcs_pkg::TOPO_BITS-1:0]   i_topology,
    input  logic [pcs_pkg::VERT_BITS-1:0]   i_vertex_count,
    input  logic [pcs_pkg::INST_BITS-1:0]   i_instance_count,
    output logic                            o_cmd_valid,
    output pcs_pkg::t_cmd                   o_cmd,
    input  logic                            i_cmd_ready
);
    import pcs_pkg::*;

    logic                   r_valid;
    t_cmd                   r_cmd;
    t_cmd                   n_cmd;
    logic [VERT_BITS-1:0]   w_n;
    logic [VERT_BITS-1:0]   w_half;
    logic [2*VERT_BITS-1:0] w_third_prod;
    logic [VERT_BITS-1:0]   w_third;

    assign w_n          = i_vertex_count;
    assign w_half       = {1'b0, w_n[VERT_BITS-1:1]};
    assign w_third_prod = {{VERT_BITS{1'b0}}, w_n} * {{VERT_BITS{1'b0}}, DIV3_RECIP};
    assign w_third      = {1'b0, w_third_prod[2*VERT_BITS-1:DIV3_SHIFT]};

    always_comb begin
        n_cmd         = '0;
        n_cmd.clear   = i_func;
        n_cmd.kind    = KIND_NONE;
        n_cmd.use_div = 1'b0;
        n_cmd.divisor = DIV_ONE;
        n_cmd.value   = '0;
        n_cmd.inst    = i_instance_count;
        unique case (i_topology) inside
            TOPO_POINTS: begin
                n_cmd.kind  = KIND_POINT;
                n_cmd.value = w_n;
            end
            TOPO_LINES, TOPO_LINES_ADJ: begin
                n_cmd.kind  = KIND_LINE;
                n_cmd.value = w_half;
            end
            TOPO_LINE_STRIP, TOPO_LINE_STRIP_ADJ: begin
                n_cmd.kind  = KIND_LINE;
                n_cmd.value = (w_n >= 32'd2) ? w_n - 32'd1 : '0;
            end
            TOPO_LINE_LOOP: begin
                n_cmd.kind = KIND_LINE;
                if (w_n == 32'd2) begin
                    n_cmd.value = 32'd1;
                end else begin
                    n_cmd.value = (w_n >= 32'd3) ? w_n : '0;
                end
            end
            TOPO_TRIS, TOPO_TRIS_ADJ: begin
                n_cmd.kind  = KIND_TRI;
                n_cmd.value = w_third;
            end
            TOPO_TRI_STRIP, TOPO_TRI_FAN, TOPO_TRI_STRIP_ADJ: begin
                n_cmd.kind  = KIND_TRI;
                n_cmd.value = (w_n >= 32'd3) ? w_n - 32'd2 : '0;
            end
            [TOPO_PATCH_FIRST:TOPO_PATCH_LAST]: begin
                n_cmd.kind    = KIND_PATCH;
                n_cmd.use_div = 1'b1;
                n_cmd.divisor = i_topology - TOPO_PATCH_BASE;
                n_cmd.value   = w_n;
            end
            default: begin
                n_cmd.kind = KIND_NONE;
            end
        endcase
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== rtl/pcs_queue.sv =====
// Short queue of classified items between front and back.
module pcs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pcs_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output pcs_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import pcs_pkg::*;

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/pcs_back.sv =====
// Back end: divides, scales by instances and accumulates the counters.
module pcs_back #(
    parameter int COUNTER_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  pcs_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_ready,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pcs_pkg::OUT_BITS-1:0]  o_draw_total,
    output logic [pcs_pkg::OUT_BITS-1:0]  o_point_total,
    output logic [pcs_pkg::OUT_BITS-1:0]  o_line_total,
    output logic [pcs_pkg::OUT_BITS-1:0]  o_triangle_total,
    output logic [pcs_pkg::OUT_BITS-1:0]  o_patch_total
);
    import pcs_pkg::*;

    localparam int unsigned STEP_W = $clog2(DIV_STEPS);
    localparam int unsigned PROD_W = VERT_BITS + INST_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_ADD
    } t_state;

    t_state                  r_state;
    t_cmd                    r_cmd;
    logic [VERT_BITS-1:0]    r_quo;
    logic [DIVR_BITS-1:0]    r_rem;
    logic [STEP_W-1:0]       r_step;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_out_valid;
    logic [COUNTER_BITS-1:0] r_draw;
    logic [COUNTER_BITS-1:0] r_point;
    logic [COUNTER_BITS-1:0] r_line;
    logic [COUNTER_BITS-1:0] r_tri;
    logic [COUNTER_BITS-1:0] r_patch;

    logic [DIVR_BITS-1:0]    w_shift;
    logic [DIVR_BITS-1:0]    w_diff;
    logic                    w_fits;
    logic [PROD_W-1:0]       w_prod;
    logic [COUNTER_BITS-1:0] w_add;
    logic                    w_out_free;

    // Remainder stays below the divisor (at most 32), so five bits carry it.
    assign w_shift    = {r_rem[DIVR_BITS-2:0], r_quo[VERT_BITS-1]};
    assign w_fits     = (w_shift >= r_cmd.divisor);
    assign w_diff     = w_shift - r_cmd.divisor;
    assign w_prod     = r_quo * r_cmd.inst;
    assign w_add      = r_prod[COUNTER_BITS-1:0];
    assign w_out_free = !r_out_valid || i_ready;

    assign o_cmd_ready      = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_draw_total     = OUT_BITS'(r_draw);
    assign o_point_total    = OUT_BITS'(r_point);
    assign o_line_total     = OUT_BITS'(r_line);
    assign o_triangle_total = OUT_BITS'(r_tri);
    assign o_patch_total    = OUT_BITS'(r_patch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_draw      <= '0;
            r_point     <= '0;
            r_line      <= '0;
            r_tri       <= '0;
            r_patch     <= '0;
        end else begin
            if (r_state == S_ADD && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd  <= i_cmd;
                        r_quo  <= i_cmd.value;
                        r_rem  <= '0;
                        r_step <= STEP_W'(DIV_STEPS - 1);
                        if (i_cmd.clear) begin
                            r_state <= S_ADD;
                        end else if (i_cmd.use_div) begin
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_DIV: begin
                    r_quo  <= {r_quo[VERT_BITS-2:0], w_fits};
                    r_rem  <= w_fits ? w_diff : w_shift;
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    // Counters double as the output register: update only
                    // once the previous result has been taken.
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                        if (r_cmd.clear) begin
                            r_draw  <= '0;
                            r_point <= '0;
                            r_line  <= '0;
                            r_tri   <= '0;
                            r_patch <= '0;
                        end else begin
                            r_draw <= r_draw + 1'b1;
                            case (r_cmd.kind)
                                KIND_POINT: r_point <= r_point + w_add;
                                KIND_LINE:  r_line  <= r_line + w_add;
                                KIND_TRI:   r_tri   <= r_tri + w_add;
                                KIND_PATCH: r_patch <= r_patch + w_add;
                                default:    ;
                            endcase
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/primitive_count_statistics_unit.sv =====
// A patch draw is divided by its patch size (32-step divide), then multiplied by
// instances and accumulated; other draws skip the divide, and a clear goes straight
// to the accumulate, which waits while a result is pending. The back end takes the
// next item only when done; front register and two-entry queue buffer items ahead.
// Reset: synchronous, active low; all counters zero, queue empty, no result
// pending. Counters wrap at COUNTER_BITS and are zero-extended to 64 bits.
module primitive_count_statistics_unit #(
    parameter int COUNTER_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_func,
    input  logic [pcs_pkg::TOPO_BITS-1:0]   i_topology,
    input  logic [pcs_pkg::VERT_BITS-1:0]   i_vertex_count,
    input  logic [pcs_pkg::INST_BITS-1:0]   i_instance_count,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pcs_pkg::OUT_BITS-1:0]    o_draw_total,
    output logic [pcs_pkg::OUT_BITS-1:0]    o_point_total,
    output logic [pcs_pkg::OUT_BITS-1:0]    o_line_total,
    output logic [pcs_pkg::OUT_BITS-1:0]    o_triangle_total,
    output logic [pcs_pkg::OUT_BITS-1:0]    o_patch_total
);
    import pcs_pkg::*;

    // Front register -> queue
    logic f_valid;
    logic f_ready;
    t_cmd f_cmd;

    // Queue -> back end
    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    // Front: registers the item and decides per-instance primitive math.
    pcs_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_topology       (i_topology),
        .i_vertex_count   (i_vertex_count),
        .i_instance_count (i_instance_count),
        .o_cmd_valid      (f_valid),
        .o_cmd            (f_cmd),
        .i_cmd_ready      (f_ready)
    );

    // Two-entry queue lets the front keep taking items during a divide.
    pcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_cmd   (f_cmd),
        .o_ready (f_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // Back: divide, multiply by instances, accumulate, hold result.
    pcs_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (q_valid),
        .i_cmd            (q_cmd),
        .o_cmd_ready      (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_draw_total     (o_draw_total),
        .o_point_total    (o_point_total),
        .o_line_total     (o_line_total),
        .o_triangle_total (o_triangle_total),
        .o_patch_total    (o_patch_total)
    );

    // Counters must not move while a result waits to be taken.
    a_hold_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_draw_total) && $stable(o_point_total)
            && $stable(o_line_total) && $stable(o_triangle_total)
            && $stable(o_patch_total))
        else $error("counters changed while result pending");

    // Draw count only holds, steps by one, or returns to zero.
    a_draw_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_draw_total == $past(o_draw_total))
            || (o_draw_total == $past(o_draw_total) + 64'd1)
            || (o_draw_total == '0))
        else $error("draw counter jumped");

endmodule

// ===== test/primitive_count_statistics_unit_tb.sv =====
// Self-checking testbench for the primitive count statistics unit.
module primitive_count_statistics_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcs_pkg::*;

    localparam int          CNT_BITS     = 64;
    localparam logic [63:0] CNT_MASK     = (CNT_BITS >= 64) ? {64{1'b1}}
                                                            : ((64'd1 << CNT_BITS) - 64'd1);
    localparam logic        FUNC_DRAW    = 1'b0;
    localparam logic        FUNC_CLEAR   = 1'b1;
    localparam logic [5:0]  TOPO_BAD_LO  = 6'd43;   // first code with no primitive kind
    localparam logic [5:0]  TOPO_BAD_HI  = 6'd63;
    localparam logic [31:0] N_MAX        = 32'hFFFF_FFFF;
    localparam int          HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int          SETTLE       = 60;      // beyond the worst divide latency
    localparam int          STALL_LIMIT  = 4000;    // cycles with no item moving
    localparam int          PRINT_LIMIT  = 40;

    typedef struct {
        logic [63:0] draw;
        logic [63:0] point;
        logic [63:0] line;
        logic [63:0] triangle;
        logic [63:0] patch;
    } t_totals;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_ready;
    logic        i_func           = FUNC_DRAW;
    logic [5:0]  i_topology       = '0;
    logic [31:0] i_vertex_count   = '0;
    logic [31:0] i_instance_count = '0;
    logic        o_valid;
    logic        i_ready          = 1'b0;
    logic [63:0] o_draw_total;
    logic [63:0] o_point_total;
    logic [63:0] o_line_total;
    logic [63:0] o_triangle_total;
    logic [63:0] o_patch_total;

    // Running counter image and the totals still owed by the block.
    t_totals     running          = '{default: 64'd0};
    t_totals     totals_q[$];

    int          err_cnt          = 0;
    int          draws_sent       = 0;
    int          clears_sent      = 0;
    int          results_checked  = 0;
    int          stall_cnt        = 0;
    int          hold_asks        = 0;
    logic        calm             = 1'b0;       // no random idling on either side

    primitive_count_statistics_unit #(
        .COUNTER_BITS(CNT_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_topology      (i_topology),
        .i_vertex_count  (i_vertex_count),
        .i_instance_count(i_instance_count),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_draw_total    (o_draw_total),
        .o_point_total   (o_point_total),
        .o_line_total    (o_line_total),
        .o_triangle_total(o_triangle_total),
        .o_patch_total   (o_patch_total)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Primitives one instance yields, and the counter they land in.
    function automatic logic [63:0] prims_per_inst(input logic [5:0] topo,
                                                   input logic [31:0] n,
                                                   output t_kind kind);
        logic [63:0] nv;
        logic [63:0] per;
        nv   = {32'd0, n};
        per  = 64'd0;
        kind = KIND_NONE;
        case (topo)
            TOPO_POINTS: begin
                kind = KIND_POINT;
                per  = nv;
            end
            TOPO_LINES, TOPO_LINES_ADJ: begin
                kind = KIND_LINE;
                per  = nv / 64'd2;
            end
            TOPO_LINE_STRIP, TOPO_LINE_STRIP_ADJ: begin
                kind = KIND_LINE;
                per  = (nv >= 64'd2) ? nv - 64'd1 : 64'd0;
            end
            TOPO_LINE_LOOP: begin
                // two vertices close into a single line
                kind = KIND_LINE;
                if (nv == 64'd2) per = 64'd1;
                else             per = (nv >= 64'd3) ? nv : 64'd0;
            end
            TOPO_TRIS, TOPO_TRIS_ADJ: begin
                kind = KIND_TRI;
                per  = nv / 64'd3;
            end
            TOPO_TRI_STRIP, TOPO_TRI_FAN, TOPO_TRI_STRIP_ADJ: begin
                kind = KIND_TRI;
                per  = (nv >= 64'd3) ? nv - 64'd2 : 64'd0;
            end
            default: begin
                if (topo >= TOPO_PATCH_FIRST && topo <= TOPO_PATCH_LAST) begin
                    kind = KIND_PATCH;
                    per  = nv / {58'd0, topo - TOPO_PATCH_BASE};
                end
            end
        endcase
        return per;
    endfunction

    // Advance the counter image by one accepted item and queue its totals.
    function automatic void update_totals(input logic f, input logic [5:0] topo,
                                          input logic [31:0] n, input logic [31:0] inst);
        t_kind       kind;
        logic [63:0] add;
        if (f == FUNC_CLEAR) begin
            running = '{default: 64'd0};
        end else begin
            add           = prims_per_inst(topo, n, kind) * {32'd0, inst};
            running.draw  = (running.draw + 64'd1) & CNT_MASK;
            case (kind)
                KIND_POINT: running.point    = (running.point + add) & CNT_MASK;
                KIND_LINE:  running.line     = (running.line + add) & CNT_MASK;
                KIND_TRI:   running.triangle = (running.triangle + add) & CNT_MASK;
                KIND_PATCH: running.patch    = (running.patch + add) & CNT_MASK;
                default: ;
            endcase
        end
        totals_q.push_back(running);
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one item and hold it until taken. Valid stays up afterwards so
    // back-to-back items never drop it within one step.
    task automatic send_item(input logic f, input logic [5:0] topo,
                             input logic [31:0] n, input logic [31:0] inst);
        if (!calm && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_func           <= f;
        i_topology       <= topo;
        i_vertex_count   <= n;
        i_instance_count <= inst;
        do @(posedge i_clk); while (!o_ready);
        update_totals(f, topo, n, inst);
        if (f == FUNC_CLEAR) clears_sent++;
        else                 draws_sent++;
    endtask

    // Stop offering and let every owed result come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (totals_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Receiver: random stalls, plus a long hold-off when a test asks for one.
    initial begin : receiver
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= calm || ($urandom_range(99) >= 8);
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_cnt < PRINT_LIMIT)
            $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_totals want;
        if (i_rst_n && o_valid && i_ready) begin
            if (totals_q.size() == 0) begin
                report_mismatch("result with nothing pending, draw_total", o_draw_total,
                                64'd0);
            end else begin
                want = totals_q.pop_front();
                results_checked++;
                if (o_draw_total !== want.draw)
                    report_mismatch("draw_total", o_draw_total, want.draw);
                if (o_point_total !== want.point)
                    report_mismatch("point_total", o_point_total, want.point);
                if (o_line_total !== want.line)
                    report_mismatch("line_total", o_line_total, want.line);
                if (o_triangle_total !== want.triangle)
                    report_mismatch("triangle_total", o_triangle_total, want.triangle);
                if (o_patch_total !== want.patch)
                    report_mismatch("patch_total", o_patch_total, want.patch);
            end
        end
    end

    // Watchdog: a correct run never goes this long without moving an item.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cnt <= 0;
        else                                              stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every fixed topology, with the small-count corners of strips and loops.
    task automatic test_topologies();
        send_item(FUNC_DRAW, TOPO_POINTS,         32'd5,  32'd1);
        send_item(FUNC_DRAW, TOPO_LINES,          32'd7,  32'd3);
        send_item(FUNC_DRAW, TOPO_LINE_STRIP,     32'd1,  32'd1);   // too short: none
        send_item(FUNC_DRAW, TOPO_LINE_LOOP,      32'd2,  32'd4);   // closes into one line
        send_item(FUNC_DRAW, TOPO_LINE_LOOP,      32'd0,  32'd2);
        send_item(FUNC_DRAW, TOPO_LINE_LOOP,      32'd3,  32'd1);
        send_item(FUNC_DRAW, TOPO_LINES_ADJ,      32'd9,  32'd1);
        send_item(FUNC_DRAW, TOPO_LINE_STRIP_ADJ, 32'd2,  32'd2);
        send_item(FUNC_DRAW, TOPO_TRIS,           32'd8,  32'd1);
        send_item(FUNC_DRAW, TOPO_TRI_STRIP,      32'd2,  32'd5);   // too short: none
        send_item(FUNC_DRAW, TOPO_TRI_FAN,        32'd3,  32'd1);
        send_item(FUNC_DRAW, TOPO_TRIS_ADJ,       32'd11, 32'd2);
        send_item(FUNC_DRAW, TOPO_TRI_STRIP_ADJ,  32'd4,  32'd1);
    endtask

    // Smallest and largest patch sizes, and codes past the patch range.
    task automatic test_patches_and_unknown();
        send_item(FUNC_DRAW, TOPO_PATCH_FIRST, 32'd7,  32'd3);
        send_item(FUNC_DRAW, TOPO_PATCH_LAST,  N_MAX,  32'd2);
        send_item(FUNC_DRAW, TOPO_PATCH_LAST,  32'd31, 32'd9);      // below one patch
        send_item(FUNC_DRAW, TOPO_BAD_LO,      32'd100, 32'd1);     // draw only
        send_item(FUNC_DRAW, TOPO_BAD_HI,      N_MAX,  N_MAX);
    endtask

    // No instances still counts a draw; a clear ignores its other fields.
    task automatic test_zero_inst_and_clear();
        send_item(FUNC_DRAW,  TOPO_TRIS,   32'd30, 32'd0);
        send_item(FUNC_CLEAR, TOPO_BAD_HI, N_MAX,  N_MAX);
        send_item(FUNC_DRAW,  TOPO_LINES,  32'd4,  32'd1);
    endtask

    // Largest adds push the counters past 2^64.
    task automatic test_wrap();
        send_item(FUNC_DRAW, TOPO_POINTS,    N_MAX, N_MAX);
        send_item(FUNC_DRAW, TOPO_POINTS,    N_MAX, N_MAX);
        send_item(FUNC_DRAW, TOPO_TRI_STRIP, N_MAX, N_MAX);
        send_item(FUNC_DRAW, TOPO_TRI_FAN,   N_MAX, N_MAX);
    endtask

    task automatic rand_item(output logic f, output logic [5:0] topo,
                             output logic [31:0] n, output logic [31:0] inst);
        int sel;
        f   = ($urandom_range(99) < 3) ? FUNC_CLEAR : FUNC_DRAW;
        sel = $urandom_range(99);
        if (sel < 10)      topo = 6'($urandom_range(TOPO_BAD_LO, TOPO_BAD_HI));
        else if (sel < 50) topo = 6'($urandom_range(TOPO_POINTS, TOPO_TRI_STRIP_ADJ));
        else               topo = 6'($urandom_range(TOPO_PATCH_FIRST, TOPO_PATCH_LAST));
        sel = $urandom_range(99);
        if (sel < 15) begin
            case ($urandom_range(5))
                0:       n = 32'd0;
                1:       n = 32'd1;
                2:       n = 32'd2;
                3:       n = 32'd3;
                4:       n = N_MAX - 32'd1;
                default: n = N_MAX;
            endcase
        end
        else if (sel < 55) n = $urandom_range(64);
        else if (sel < 75) n = $urandom_range(4096);
        else               n = $urandom;
        sel = $urandom_range(99);
        if (sel < 5)       inst = 32'd0;
        else if (sel < 35) inst = 32'd1;
        else if (sel < 65) inst = $urandom_range(16);
        else               inst = $urandom;
    endtask

    // Receiver holds off long enough for the block to fill and stall its
    // input while fast topologies keep coming.
    task automatic test_backpressure();
        logic        f;
        logic [5:0]  topo;
        logic [31:0] n;
        logic [31:0] inst;
        hold_asks <= hold_asks + 1;
        for (int i = 0; i < 24; i++) begin
            f    = FUNC_DRAW;
            topo = (i % 3 == 0) ? TOPO_POINTS : TOPO_BAD_LO;
            n    = $urandom;
            inst = $urandom_range(8);
            if (i == 12) f = FUNC_CLEAR;
            send_item(f, topo, n, inst);
        end
        wait_drained();
    endtask

    // Bulk random traffic, with a quiet stretch and a few full drains.
    task automatic test_random(input int count);
        logic        f;
        logic [5:0]  topo;
        logic [31:0] n;
        logic [31:0] inst;
        for (int i = 0; i < count; i++) begin
            if (i == count / 3)     calm <= 1'b1;
            if (i == count / 2)     calm <= 1'b0;
            if (i % 250 == 249)     wait_drained();
            rand_item(f, topo, n, inst);
            send_item(f, topo, n, inst);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_topologies();
        test_patches_and_unknown();
        test_zero_inst_and_clear();
        test_wrap();
        wait_drained();
        test_backpressure();
        test_random(1000);
        wait_drained();

        if (totals_q.size() != 0)
            report_mismatch("results never returned, count", 64'(totals_q.size()), 64'd0);

        $display("Covered %0d draws over all topologies incl. unknown codes, %0d clears,",
                 draws_sent, clears_sent);
        $display("counter wrap, zero instances, long receiver hold-off; %0d results checked.",
                 results_checked);
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
